// ----- rtl/wwkm_pkg.sv -----
`default_nettype none
package wwkm_pkg;

  // Default maximum keyword length, in characters.
  localparam int MAX_KEYWORD_DEF = 8;

  // Field and register widths fixed by the interface.
  localparam int TEXT_W     = 8;
  localparam int KW_BYTES_W = 64;
  localparam int KW_LEN_W   = 4;

  // APB port: two registers on an 8-byte pitch.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam int REG_SEL_BIT = 3;

  // Register indexes, decoded from the register select bit of paddr.
  localparam logic REG_KEYWORD_BYTES  = 1'b0;
  localparam logic REG_KEYWORD_LENGTH = 1'b1;

  // Reset values of the registers.
  localparam logic [KW_BYTES_W-1:0] KW_BYTES_RST = '0;
  localparam logic [KW_LEN_W-1:0]   KW_LEN_RST   = KW_LEN_W'(1);

  // Character constants.
  localparam logic [TEXT_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [TEXT_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [TEXT_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [TEXT_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [TEXT_W-1:0] CASE_OFFSET  = 8'h20;

  // Configuration as seen by the matcher.
  typedef struct packed {
    logic [KW_BYTES_W-1:0] keyword_bytes;
    logic [KW_LEN_W-1:0]   keyword_length;
  } cfg_t;

  // One transaction handed from the input register to the matcher.
  typedef struct packed {
    logic              valid;
    logic              end_of_line;
    logic [TEXT_W-1:0] text_byte;
  } step_t;

  function automatic logic is_upper(input logic [TEXT_W-1:0] c);
    return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
  endfunction

  function automatic logic is_letter(input logic [TEXT_W-1:0] c);
    return is_upper(c) || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  endfunction

  function automatic logic [TEXT_W-1:0] fold_case(input logic [TEXT_W-1:0] c);
    return is_upper(c) ? (c + CASE_OFFSET) : c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/wwkm_cfg.sv -----
`default_nettype none
module wwkm_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [wwkm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [wwkm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [wwkm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output wwkm_pkg::cfg_t                         cfg_o
);

  logic [wwkm_pkg::KW_BYTES_W-1:0] kw_bytes_q;
  logic [wwkm_pkg::KW_LEN_W-1:0]   kw_len_q;
  logic                            wr_en;
  logic                            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[wwkm_pkg::REG_SEL_BIT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_bytes_q <= wwkm_pkg::KW_BYTES_RST;
      kw_len_q   <= wwkm_pkg::KW_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        wwkm_pkg::REG_KEYWORD_BYTES:  kw_bytes_q <= pwdata[wwkm_pkg::KW_BYTES_W-1:0];
        wwkm_pkg::REG_KEYWORD_LENGTH: kw_len_q   <= pwdata[wwkm_pkg::KW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      wwkm_pkg::REG_KEYWORD_BYTES:  prdata = wwkm_pkg::APB_DATA_W'(kw_bytes_q);
      wwkm_pkg::REG_KEYWORD_LENGTH: prdata = wwkm_pkg::APB_DATA_W'(kw_len_q);
      default:                      prdata = '0;
    endcase
  end

  assign cfg_o.keyword_bytes  = kw_bytes_q;
  assign cfg_o.keyword_length = kw_len_q;

endmodule
`default_nettype wire

// ----- rtl/wwkm_window.sv -----
`default_nettype none
module wwkm_window #(
  parameter int MaxKeyword = wwkm_pkg::MAX_KEYWORD_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire wwkm_pkg::cfg_t  cfg_i,
  input  wire wwkm_pkg::step_t step_i,
  output logic                 matched_o
);

  localparam int Depth  = MaxKeyword + 1;
  localparam int SeenW  = $clog2(MaxKeyword + 2);
  localparam int TextW  = wwkm_pkg::TEXT_W;
  localparam int LenW   = wwkm_pkg::KW_LEN_W;

  logic [TextW-1:0] win_q [Depth];
  logic [TextW-1:0] win_d [Depth];
  logic [SeenW-1:0] seen_q, seen_d;
  logic             await_q, await_d;
  logic             found_q, found_d;
  logic [LenW-1:0]  len_eff;
  logic             chars_eq;
  logic [TextW-1:0] text_char;
  logic [TextW-1:0] left_char;
  logic             hit;

  // Shifted window: the new byte lands at index 0.
  always_comb begin
    win_d[0] = step_i.text_byte;
    for (int i = 1; i < Depth; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  always_comb begin
    if (cfg_i.keyword_length == '0) begin
      len_eff = LenW'(1);
    end else if (cfg_i.keyword_length > LenW'(MaxKeyword)) begin
      len_eff = LenW'(MaxKeyword);
    end else begin
      len_eff = cfg_i.keyword_length;
    end
  end

  assign seen_d = (seen_q < SeenW'(Depth)) ? (seen_q + SeenW'(1)) : seen_q;

  // Keyword character k lines up with window byte len-1-k.
  always_comb begin
    chars_eq  = 1'b1;
    text_char = '0;
    for (int k = 0; k < MaxKeyword; k++) begin
      text_char = '0;
      for (int j = 0; j < MaxKeyword; j++) begin
        if (j + k + 1 == int'(len_eff)) begin
          text_char = win_d[j];
        end
      end
      if ((k < int'(len_eff)) &&
          (wwkm_pkg::fold_case(cfg_i.keyword_bytes[8*k +: 8]) !=
           wwkm_pkg::fold_case(text_char))) begin
        chars_eq = 1'b0;
      end
    end
  end

  always_comb begin
    left_char = '0;
    for (int j = 0; j < Depth; j++) begin
      if (j == int'(len_eff)) begin
        left_char = win_d[j];
      end
    end
  end

  assign hit = (int'(seen_d) >= int'(len_eff)) && chars_eq &&
               ((int'(seen_d) == int'(len_eff)) || !wwkm_pkg::is_letter(left_char));

  assign await_d = hit;
  assign found_d = found_q || (await_q && !wwkm_pkg::is_letter(step_i.text_byte));

  // Window bytes beyond the fill count are never consulted, so they need no clearing.
  always_ff @(posedge clk_i) begin
    if (step_i.valid && !step_i.end_of_line) begin
      for (int i = 0; i < Depth; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      await_q <= 1'b0;
      found_q <= 1'b0;
    end else if (step_i.valid) begin
      if (step_i.end_of_line) begin
        seen_q  <= '0;
        await_q <= 1'b0;
        found_q <= 1'b0;
      end else begin
        seen_q  <= seen_d;
        await_q <= await_d;
        found_q <= found_d;
      end
    end
  end

  // A match still waiting for its right boundary is closed by the end of line.
  assign matched_o = found_q || await_q;

endmodule
`default_nettype wire

// ----- rtl/whole_word_keyword_matcher.sv -----
`default_nettype none
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   text_byte_i[7:0], end_of_line_i
// output    out        out_valid_o/out_stall_i line_matched_o
// config    in/out     APB (psel, penable)     paddr[3:0], pwdata/prdata[63:0]
//
// Each transaction enters the input register; an end-of-line one then loads the result
// register. A new transaction is accepted in every cycle unless the input side stalls:
// the window compare is one shallow level of logic from input register to match state.
// Reset is asynchronous and active low; it empties both registers, clears the line
// state and loads the keyword registers with a keyword of one NUL character.
// Only end-of-line transactions produce a result. A stalled result holds in the output
// register; the input side stalls only when an end-of-line transaction waits behind it.
module whole_word_keyword_matcher #(
  parameter int MaxKeyword = wwkm_pkg::MAX_KEYWORD_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [wwkm_pkg::TEXT_W-1:0]     text_byte_i,
  input  wire logic                            end_of_line_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 line_matched_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wwkm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [wwkm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [wwkm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  wwkm_pkg::cfg_t  cfg;
  wwkm_pkg::step_t step;

  // Input register.
  logic                        s1_valid_q, s1_valid_d;
  logic                        s1_eol_q;
  logic [wwkm_pkg::TEXT_W-1:0] s1_byte_q;
  logic                        s1_adv;
  logic                        in_take;

  // Result register.
  logic out_valid_q, out_valid_d;
  logic out_match_q;
  logic matched;

  wwkm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // A text byte always moves on; an end-of-line needs room in the result register.
  assign s1_adv  = s1_valid_q && (!s1_eol_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take = in_valid_i && !in_stall_o;

  assign step.valid       = s1_adv;
  assign step.end_of_line = s1_eol_q;
  assign step.text_byte   = s1_byte_q;

  wwkm_window #(
    .MaxKeyword(MaxKeyword)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .matched_o(matched)
  );

  assign s1_valid_d  = in_take || (s1_valid_q && !s1_adv);
  assign out_valid_d = (s1_adv && s1_eol_q) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= text_byte_i;
      s1_eol_q  <= end_of_line_i;
    end
    if (s1_adv && s1_eol_q) begin
      out_match_q <= matched;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_matched_o = out_match_q;

endmodule
`default_nettype wire

// ----- rtl/wwkm_checker.sv -----
`default_nettype none
module wwkm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic                            line_matched_o,
  input wire logic                            psel,
  input wire logic                            pwrite,
  input wire logic [wwkm_pkg::APB_ADDR_W-1:0] paddr,
  input wire logic [wwkm_pkg::APB_DATA_W-1:0] prdata,
  input wire logic                            pready
);

  // A result that is held back keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_matched_o))
    else $error("stalled result changed");

  // With the result register empty the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // The keyword length register reads back as four bits only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr[wwkm_pkg::REG_SEL_BIT] |->
      prdata[wwkm_pkg::APB_DATA_W-1:wwkm_pkg::KW_LEN_W] == '0)
    else $error("keyword length read back wider than four bits");

  // The input side stalls only while a result is pending and held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && pready)
    else $error("input stalled without a held result");

endmodule

bind whole_word_keyword_matcher wwkm_checker u_wwkm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .line_matched_o(line_matched_o),
  .psel          (psel),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .prdata        (prdata),
  .pready        (pready)
);
`default_nettype wire

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Self-checking testbench for whole_word_keyword_matcher.
  //
  // Lines of text are sent into the block one byte per transaction. Each line is
  // closed by an end-of-line transaction. A predictor written in this file tracks
  // the matcher state in parallel and queues one expected verdict per line. A
  // separate checker compares each verdict the block returns against the oldest
  // queued one. The keyword registers are written over the APB port only while
  // the block has nothing outstanding, and each write is read back.
  //
  // Test tasks, in the order they are called:
  //   test_reset_keyword   - default keyword (one NUL character) and an empty line
  //   test_case_folding    - mixed-case keyword, letters glued to the keyword
  //   test_short_line      - a line shorter than the keyword
  //   test_length_limits   - keyword length zero and above eight, high bytes
  //   test_config_mid_line - keyword change inside a line with a pending boundary
  //   test_random_text     - phases of random keywords and mostly well-formed lines

  localparam int MAX_KEYWORD_DEF = wwkm_pkg::MAX_KEYWORD_DEF;
  localparam int TEXT_W          = wwkm_pkg::TEXT_W;
  localparam int KW_BYTES_W      = wwkm_pkg::KW_BYTES_W;
  localparam int KW_LEN_W        = wwkm_pkg::KW_LEN_W;
  localparam int APB_ADDR_W      = wwkm_pkg::APB_ADDR_W;
  localparam int APB_DATA_W      = wwkm_pkg::APB_DATA_W;
  localparam int REG_SEL_BIT     = wwkm_pkg::REG_SEL_BIT;

  localparam logic REG_KEYWORD_BYTES  = wwkm_pkg::REG_KEYWORD_BYTES;
  localparam logic REG_KEYWORD_LENGTH = wwkm_pkg::REG_KEYWORD_LENGTH;

  localparam logic [KW_BYTES_W-1:0] KW_BYTES_RST = wwkm_pkg::KW_BYTES_RST;
  localparam logic [KW_LEN_W-1:0]   KW_LEN_RST   = wwkm_pkg::KW_LEN_RST;

  localparam logic [TEXT_W-1:0] CHAR_LOWER_A = wwkm_pkg::CHAR_LOWER_A;
  localparam logic [TEXT_W-1:0] CHAR_LOWER_Z = wwkm_pkg::CHAR_LOWER_Z;
  localparam logic [TEXT_W-1:0] CHAR_UPPER_A = wwkm_pkg::CHAR_UPPER_A;
  localparam logic [TEXT_W-1:0] CHAR_UPPER_Z = wwkm_pkg::CHAR_UPPER_Z;
  localparam logic [TEXT_W-1:0] CASE_OFFSET  = wwkm_pkg::CASE_OFFSET;

  // The output side holds a result, and the sender pauses, only for as long as
  // gap_len allows. This limit lies far beyond that, so it leaves a wide margin
  // before a quiet run is taken as a hang.
  localparam int IDLE_LIMIT   = 2000;
  // An accepted transaction is held in the input register and then taken into
  // the window state. Text bytes give no result, so the sender waits out
  // SETTLE_CYCLES for them to settle before a register write.
  localparam int SETTLE_CYCLES = 4;
  localparam int WINDOW        = MAX_KEYWORD_DEF + 1;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 195;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [TEXT_W-1:0]     text_byte_i    = '0;
  logic                  end_of_line_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  line_matched_o;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  whole_word_keyword_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_matched_o(line_matched_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: our own copy of the keyword registers and of the line
  // window. The newest byte sits at index 0 of the window.
  logic [KW_BYTES_W-1:0] kw_chars   = KW_BYTES_RST;
  logic [KW_LEN_W-1:0]   kw_len_reg = KW_LEN_RST;
  logic [TEXT_W-1:0]     win [0:WINDOW-1];
  int                    win_fill;
  bit                    pending_edge;
  bit                    line_hit;

  // Verdicts the block still owes us, oldest first.
  bit verdict_q [$];

  // The line being assembled by the random generator.
  logic [TEXT_W-1:0] line_buf [$];

  // When set, neither side inserts gaps or stalls.
  bit no_gaps = 1'b0;

  int errors;
  int lines_sent;
  int lines_hit;
  int bytes_sent;
  int reg_writes;
  int idle_cycles;

  function automatic bit alpha(input logic [TEXT_W-1:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
  endfunction

  function automatic logic [TEXT_W-1:0] fold_lower(input logic [TEXT_W-1:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // A length of zero counts as one; anything above MAX_KEYWORD_DEF is clipped to it.
  function automatic int eff_len(input logic [KW_LEN_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end
    if (raw > MAX_KEYWORD_DEF) begin
      return MAX_KEYWORD_DEF;
    end
    return raw;
  endfunction

  function automatic void clear_line();
    foreach (win[i]) begin
      win[i] = '0;
    end
    win_fill     = 0;
    pending_edge = 1'b0;
    line_hit     = 1'b0;
  endfunction

  // Advances the predictor by one accepted transaction.
  function automatic void predict_step(input logic [TEXT_W-1:0] b, input logic eol);
    int n;
    bit same;
    if (eol) begin
      if (pending_edge) begin
        line_hit = 1'b1;
      end
      verdict_q.push_back(line_hit);
      lines_sent++;
      if (line_hit) begin
        lines_hit++;
      end
      clear_line();
    end else begin
      // A match that ended at the previous byte needs a non-letter after it.
      if (pending_edge && !alpha(b)) begin
        line_hit = 1'b1;
      end
      pending_edge = 1'b0;
      for (int i = WINDOW - 1; i > 0; i--) begin
        win[i] = win[i-1];
      end
      win[0] = b;
      if (win_fill < WINDOW) begin
        win_fill++;
      end
      n = eff_len(kw_len_reg);
      if (win_fill >= n) begin
        same = 1'b1;
        for (int k = 0; k < n; k++) begin
          if (fold_lower(kw_chars[8*k +: 8]) != fold_lower(win[n-1-k])) begin
            same = 1'b0;
          end
        end
        // The left boundary is either the line start or a non-letter.
        if (same && (win_fill == n || !alpha(win[n]))) begin
          pending_edge = 1'b1;
        end
      end
      bytes_sent++;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [TEXT_W-1:0] any_letter();
    return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) +
           TEXT_W'($urandom_range(0, 25));
  endfunction

  // Non-letters, with weight on the bytes right next to the letter ranges.
  function automatic logic [TEXT_W-1:0] any_separator();
    case ($urandom_range(0, 7))
      0: return 8'h20;
      1: return TEXT_W'($urandom_range(8'h21, 8'h40));
      2: return TEXT_W'($urandom_range(8'h5b, 8'h60));
      3: return TEXT_W'($urandom_range(8'h7b, 8'h7f));
      4: return 8'h00;
      5: return 8'h0a;
      6: return TEXT_W'($urandom_range(8'h80, 8'hff));
      default: return TEXT_W'($urandom_range(8'h01, 8'h1f));
    endcase
  endfunction

  // Appends the current keyword to the line, letters in random case.
  function automatic void push_keyword(input int corrupt_at);
    logic [TEXT_W-1:0] c;
    for (int k = 0; k < eff_len(kw_len_reg); k++) begin
      c = kw_chars[8*k +: 8];
      if (alpha(c) && $urandom_range(0, 1)) begin
        c = c ^ CASE_OFFSET;
      end
      // Flipping the lowest bit never yields the same character, in any case.
      if (k == corrupt_at) begin
        c = c ^ 8'h01;
      end
      line_buf.push_back(c);
    end
  endfunction

  function automatic void build_line();
    int n_tokens;
    line_buf.delete();
    // A tenth of the lines is plain noise.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 16)) line_buf.push_back(TEXT_W'($urandom));
    end else begin
      n_tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
      for (int t = 0; t < n_tokens; t++) begin
        if (t > 0 && $urandom_range(0, 9) < 7) begin
          line_buf.push_back(any_separator());
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_keyword(-1);
          4: begin
            // Keyword with a letter glued to its front.
            line_buf.push_back(any_letter());
            push_keyword(-1);
          end
          5: begin
            // Keyword with a letter glued to its end.
            push_keyword(-1);
            line_buf.push_back(any_letter());
          end
          6: push_keyword($urandom_range(0, eff_len(kw_len_reg) - 1));
          7, 8: repeat ($urandom_range(1, 6)) line_buf.push_back(any_letter());
          default: repeat ($urandom_range(1, 3)) line_buf.push_back(any_separator());
        endcase
      end
    end
  endfunction

  // Sends one transaction and waits until the block takes it. Valid stays
  // high into the next call unless that call starts with a gap.
  task automatic send_item(input logic [TEXT_W-1:0] b, input logic eol);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_line_i <= eol;
    do @(posedge clk_i); while (in_stall_o);
    predict_step(b, eol);
  endtask

  // The byte that travels with an end-of-line transaction is don't-care, so
  // it is random.
  task automatic end_line();
    send_item(TEXT_W'($urandom), 1'b1);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) begin
      send_item(line_buf[i], 1'b0);
    end
    end_line();
  endtask

  // Holds the sender until every verdict is back and the pipeline has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a read of the same register. The read goes straight
  // from the write's access phase into its own setup phase.
  task automatic set_register(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] mask;
    addr = '0;
    addr[REG_SEL_BIT] = reg_idx;
    mask = (reg_idx == REG_KEYWORD_LENGTH) ? APB_DATA_W'({KW_LEN_W{1'b1}}) : '1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      $error("prdata: expected %h, actual %h", value & mask, prdata & mask);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == REG_KEYWORD_BYTES) begin
      kw_chars = value;
    end else begin
      kw_len_reg = value[KW_LEN_W-1:0];
    end
    reg_writes++;
  endtask

  // The output side stalls in runs of random length, separated by short
  // stretches where it takes every result.
  always begin
    int n;
    @(posedge clk_i);
    n = gap_len();
    if (n > 0) begin
      out_stall_i <= 1'b1;
      repeat (n) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
    repeat ($urandom_range(0, 7)) @(posedge clk_i);
  end

  // Each accepted result is checked against the oldest verdict still owed.
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("line_matched: no result expected, actual %0b", line_matched_o);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (line_matched_o !== want) begin
          $error("line_matched: expected %0b, actual %0b", want, line_matched_o);
          errors++;
        end
      end
    end
  end

  // Ends the run if neither channel nor the register port moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // After reset the keyword is a single NUL character, so a line holding just
  // that byte matches, while an empty line does not.
  task automatic test_reset_keyword();
    send_item(8'h00, 1'b0);
    end_line();
    end_line();
  endtask

  // Keyword "Ab": "aB." holds it as a whole word, "xab" only glued to a letter.
  task automatic test_case_folding();
    wait_idle();
    set_register(REG_KEYWORD_BYTES, 64'h6241);
    set_register(REG_KEYWORD_LENGTH, 64'd2);
    send_item(8'h61, 1'b0);
    send_item(8'h42, 1'b0);
    send_item(8'h2e, 1'b0);
    end_line();
    send_item(8'h78, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    end_line();
  endtask

  // One byte of a two-byte keyword can never match.
  task automatic test_short_line();
    send_item(8'h61, 1'b0);
    end_line();
  endtask

  // All-ones keyword bytes are compared without folding. A length of zero
  // acts as one, and fifteen is clipped to eight, the maximum keyword length.
  task automatic test_length_limits();
    wait_idle();
    set_register(REG_KEYWORD_BYTES, '1);
    set_register(REG_KEYWORD_LENGTH, 64'd0);
    send_item(8'hff, 1'b0);
    end_line();
    wait_idle();
    set_register(REG_KEYWORD_LENGTH, 64'd15);
    repeat (MAX_KEYWORD_DEF) send_item(8'hff, 1'b0);
    end_line();
  endtask

  // "z" matches and waits for its right boundary. The keyword then changes
  // inside the line, and the newline byte that follows must still close the
  // earlier match.
  task automatic test_config_mid_line();
    wait_idle();
    set_register(REG_KEYWORD_BYTES, 64'h7a);
    set_register(REG_KEYWORD_LENGTH, 64'd1);
    send_item(8'h7a, 1'b0);
    wait_idle();
    set_register(REG_KEYWORD_LENGTH, 64'd2);
    send_item(8'h0a, 1'b0);
    end_line();
  endtask

  // Each phase draws a new keyword and then streams lines built around it.
  // One phase runs with no gaps and no stalls at all.
  task automatic test_random_text();
    logic [KW_BYTES_W-1:0] chars;
    logic [KW_LEN_W-1:0]   len_raw;
    int                    r;
    int                    start;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      no_gaps = (phase == 3);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len_raw = '0;
      end else if (r < 16) begin
        len_raw = KW_LEN_W'($urandom_range(MAX_KEYWORD_DEF + 1, 15));
      end else begin
        len_raw = KW_LEN_W'($urandom_range(1, MAX_KEYWORD_DEF));
      end
      // Bytes above the keyword length stay random; they must not matter.
      chars = {$urandom, $urandom};
      if ($urandom_range(0, 9) != 0) begin
        for (int k = 0; k < eff_len(len_raw); k++) begin
          chars[8*k +: 8] = ($urandom_range(0, 4) == 0) ? any_separator() : any_letter();
        end
      end
      set_register(REG_KEYWORD_BYTES, chars);
      set_register(REG_KEYWORD_LENGTH, APB_DATA_W'(len_raw));
      start = bytes_sent + lines_sent;
      while (bytes_sent + lines_sent - start < PHASE_ITEMS) begin
        build_line();
        send_line();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clear_line();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_keyword();
    test_case_folding();
    test_short_line();
    test_length_limits();
    test_config_mid_line();
    test_random_text();
    wait_idle();
    $display("Sent %0d lines with %0d text bytes; %0d lines held the keyword as a whole word.",
             lines_sent, bytes_sent, lines_hit);
    $display("Keyword registers were written and read back %0d times.", reg_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
